// ----- sv/llti_pkg.sv -----
// ============================================================================
// llti_pkg
// Shared types, codes and constants of the log-log table interpolator.
// ============================================================================
package llti_pkg;

   // item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Q8.16 log2 limits and the log2 of 1e-38 used for zero
   localparam logic [23:0] LOG_MAX  = 24'h7FFFFF;
   localparam logic [23:0] LOG_MIN  = 24'h800000;
   localparam logic [23:0] LOG_ZERO = 24'(-8272823);

   // iteration counts of the shared datapath units
   localparam int LOG_STEPS = 16;
   localparam int DIV_STEPS = 49;
   localparam int EXP_STEPS = 16;
   localparam int CNT_W     = 6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] x_value;
      logic [31:0] y_value;
   } req_word_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        status;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_LOG_RUN, ST_LOG_FIN, ST_LOG_Y,
      ST_SCAN_RD, ST_SCAN_CMP, ST_SHIFT_CHK, ST_SHIFT_WR, ST_INS_WR,
      ST_RD_A, ST_RD_B, ST_GOT_B, ST_MUL, ST_SEG,
      ST_DIV_RUN, ST_DIV_FIN, ST_EXP_INIT, ST_EXP_RUN, ST_EMIT
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_CAPTURE, OP_CLEAR, OP_EMIT_ERR,
      OP_LOG_SETUP_X, OP_LOG_SETUP_Y, OP_LOG_STEP, OP_LOG_FIN_X, OP_LOG_FIN_Y,
      OP_SCAN_READ, OP_IDX_INC, OP_SH_INIT, OP_SHIFT_READ, OP_SHIFT_WRITE,
      OP_INSERT, OP_READ_A, OP_READ_B, OP_LATCH_B, OP_MULT,
      OP_SET_LQ_RY, OP_SET_LQ_END, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_FIN,
      OP_EXP_INIT, OP_EXP_STEP, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [CNT_W-1:0] cnt;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       few;
      logic       at_end;
      logic       sh_at_pos;
      logic       scan_go;
      logic       eq;
      logic       dx_zero;
   } dp_stat_type;

   // 2^(2^-k) in Q1.30 by k nested truncated square roots, elaboration only
   function automatic logic [30:0] exp_root(input int k);
      logic [63:0] c;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bt;
      c = 64'd1 << 31;
      for (int j = 1; j <= EXP_STEPS; j++) begin
         if (j <= k) begin
            v   = c << 30;
            res = 64'd0;
            bt  = 64'd1 << 62;
            for (int s = 0; s < 32; s++) begin
               if (v >= res + bt) begin
                  v   = v - (res + bt);
                  res = (res >> 1) + bt;
               end else begin
                  res = res >> 1;
               end
               bt = bt >> 2;
            end
            c = res;
         end
      end
      return c[30:0];
   endfunction

endpackage

// ----- sv/llti_controller.sv -----
// ============================================================================
// llti_controller
// Sequencer: walks each load or query through log conversion, table scan, insert or
// segment fetch, divide and exp2, issuing one datapath command per cycle.
// ============================================================================
module llti_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  llti_pkg::dp_stat_type stat,
   output llti_pkg::dp_cmd_type  cmd
);
   import llti_pkg::*;

   ctl_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ylog_ff, ylog_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ylog_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ylog_ff  <= ylog_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ylog_in  = ylog_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            ylog_in = 1'b0;
            case (stat.kind)
               KIND_LOAD:  state_in = stat.full ? ST_IDLE : ST_LOG_RUN;
               KIND_QUERY: state_in = stat.few ? ST_IDLE : ST_LOG_RUN;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_LOG_RUN: begin
            if (cnt_ff == CNT_W'(LOG_STEPS - 1)) state_in = ST_LOG_FIN;
         end
         ST_LOG_FIN: begin
            if (!ylog_ff && stat.kind == KIND_LOAD) state_in = ST_LOG_Y;
            else state_in = ST_SCAN_RD;
         end
         ST_LOG_Y: begin
            ylog_in  = 1'b1;
            state_in = ST_LOG_RUN;
         end
         ST_SCAN_RD: begin
            if (!stat.at_end) state_in = ST_SCAN_CMP;
            else if (stat.kind == KIND_LOAD) state_in = ST_SHIFT_CHK;
            else state_in = ST_RD_A;
         end
         ST_SCAN_CMP: begin
            if (stat.scan_go) state_in = ST_SCAN_RD;
            else if (stat.kind == KIND_LOAD) state_in = ST_SHIFT_CHK;
            else if (stat.eq) state_in = ST_EXP_INIT;
            else state_in = ST_RD_A;
         end
         ST_SHIFT_CHK: state_in = stat.sh_at_pos ? ST_INS_WR : ST_SHIFT_WR;
         ST_SHIFT_WR:  state_in = ST_SHIFT_CHK;
         ST_INS_WR:    state_in = ST_IDLE;
         ST_RD_A:      state_in = ST_RD_B;
         ST_RD_B:      state_in = ST_GOT_B;
         ST_GOT_B:     state_in = ST_MUL;
         ST_MUL:       state_in = ST_SEG;
         ST_SEG:       state_in = stat.dx_zero ? ST_EXP_INIT : ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_DIV_FIN;
         end
         ST_DIV_FIN:   state_in = ST_EXP_INIT;
         ST_EXP_INIT:  state_in = ST_EXP_RUN;
         ST_EXP_RUN: begin
            if (cnt_ff == CNT_W'(EXP_STEPS - 1)) state_in = ST_EMIT;
         end
         ST_EMIT:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // step counter runs only inside the iterating states
   always_comb begin
      case (state_ff)
         ST_LOG_RUN, ST_DIV_RUN, ST_EXP_RUN: cnt_in = cnt_ff + CNT_W'(1);
         default:                            cnt_in = '0;
      endcase
   end

   // datapath command
   always_comb begin
      cmd.cnt = cnt_ff;
      cmd.op  = OP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (start) cmd.op = OP_CAPTURE;
         end
         ST_DISPATCH: begin
            case (stat.kind)
               KIND_CLEAR: cmd.op = OP_CLEAR;
               KIND_LOAD:  cmd.op = stat.full ? OP_NOP : OP_LOG_SETUP_X;
               KIND_QUERY: cmd.op = stat.few ? OP_EMIT_ERR : OP_LOG_SETUP_X;
               default:    cmd.op = OP_NOP;
            endcase
         end
         ST_LOG_RUN:  cmd.op = OP_LOG_STEP;
         ST_LOG_FIN:  cmd.op = ylog_ff ? OP_LOG_FIN_Y : OP_LOG_FIN_X;
         ST_LOG_Y:    cmd.op = OP_LOG_SETUP_Y;
         ST_SCAN_RD: begin
            if (!stat.at_end) cmd.op = OP_SCAN_READ;
            else if (stat.kind == KIND_LOAD) cmd.op = OP_SH_INIT;
            else cmd.op = OP_NOP;
         end
         ST_SCAN_CMP: begin
            if (stat.scan_go) cmd.op = OP_IDX_INC;
            else if (stat.kind == KIND_LOAD) cmd.op = OP_SH_INIT;
            else if (stat.eq) cmd.op = OP_SET_LQ_RY;
            else cmd.op = OP_NOP;
         end
         ST_SHIFT_CHK: cmd.op = stat.sh_at_pos ? OP_NOP : OP_SHIFT_READ;
         ST_SHIFT_WR:  cmd.op = OP_SHIFT_WRITE;
         ST_INS_WR:    cmd.op = OP_INSERT;
         ST_RD_A:      cmd.op = OP_READ_A;
         ST_RD_B:      cmd.op = OP_READ_B;
         ST_GOT_B:     cmd.op = OP_LATCH_B;
         ST_MUL:       cmd.op = OP_MULT;
         ST_SEG:       cmd.op = stat.dx_zero ? OP_SET_LQ_END : OP_DIV_INIT;
         ST_DIV_RUN:   cmd.op = OP_DIV_STEP;
         ST_DIV_FIN:   cmd.op = OP_DIV_FIN;
         ST_EXP_INIT:  cmd.op = OP_EXP_INIT;
         ST_EXP_RUN:   cmd.op = OP_EXP_STEP;
         ST_EMIT:      cmd.op = OP_EMIT;
         default:      cmd.op = OP_NOP;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- sv/llti_datapath.sv -----
// ============================================================================
// llti_datapath
// Point tables, log2 squaring unit, restoring divider, exp2 product unit and
// the result register, all driven by controller commands.
// ============================================================================
module llti_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  llti_pkg::dp_cmd_type   cmd,
   input  llti_pkg::req_word_type req_word,
   output llti_pkg::dp_stat_type  stat,
   output logic                  rsp_strobe,
   output llti_pkg::rsp_word_type rsp_word
);
   import llti_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // point tables
   logic [23:0] mem_x [TABLE_DEPTH];
   logic [23:0] mem_y [TABLE_DEPTH];

   req_word_type word_ff, word_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, sh_ff, sh_in;
   logic [30:0] sq_ff, sq_in;
   logic [15:0] frac_ff, frac_in;
   logic [8:0]  ip_ff, ip_in;
   logic        spec_ff, spec_in;
   logic [23:0] spec_val_ff, spec_val_in;
   logic [23:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [23:0] rx_ff, ry_ff;
   logic [23:0] x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [49:0] prod_ff, prod_in;
   logic [23:0] dx_ff, dx_in;
   logic        neg_ff, neg_in;
   logic [48:0] num_ff, num_in;
   logic [23:0] rem_ff, rem_in;
   logic [23:0] lq_ff, lq_in;
   logic [30:0] r_ff, r_in;
   logic [8:0]  e_ff, e_in;
   logic        strobe_ff, strobe_in;
   rsp_word_type rsp_ff, rsp_in;

   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [23:0]   wr_x, wr_y;

   // exp2 root constants
   logic [30:0] exp_c [EXP_STEPS];
   for (genvar g = 0; g < EXP_STEPS; g++) begin : g_root
      localparam logic [30:0] ROOT = exp_root(g + 1);
      assign exp_c[g] = ROOT;
   end

   // log2 setup: unpack the float being converted
   logic [31:0] src_bits;
   logic [7:0]  src_ex;
   logic [22:0] src_man;
   logic [4:0]  lead_p;
   logic [30:0] sub_sq;
   assign src_bits = (cmd.op == OP_LOG_SETUP_Y) ? word_ff.y_value : word_ff.x_value;
   assign src_ex   = src_bits[30:23];
   assign src_man  = src_bits[22:0];

   always_comb begin
      lead_p = '0;
      for (int i = 0; i < 23; i++) begin
         if (src_man[i]) lead_p = 5'(i);
      end
   end
   assign sub_sq = {8'b0, src_man} << (5'd30 - lead_p);

   // log2 squaring step
   logic [61:0] sq_prod;
   logic [31:0] sq_t;
   assign sq_prod = sq_ff * sq_ff;
   assign sq_t    = sq_prod[61:30];

   // log2 final value
   logic signed [24:0] log_raw;
   logic [23:0]        log_val;
   assign log_raw = $signed({ip_ff, frac_ff});
   always_comb begin
      if (spec_ff) log_val = spec_val_ff;
      else if (log_raw < -25'sd8388608) log_val = LOG_MIN;
      else log_val = log_raw[23:0];
   end

   // segment start: first pair, last pair, or the bracketing pair
   logic [CW-1:0] seg_a, seg_b;
   always_comb begin
      if (idx_ff == '0) seg_a = '0;
      else if (idx_ff == count_ff) seg_a = count_ff - CW'(2);
      else seg_a = idx_ff - CW'(1);
   end
   assign seg_b = seg_a + CW'(1);

   // log-domain slope numerator
   logic signed [24:0] dy, dxq;
   logic signed [49:0] mul_p;
   assign dy    = $signed({y1_ff[23], y1_ff}) - $signed({y0_ff[23], y0_ff});
   assign dxq   = $signed({lx_ff[23], lx_ff}) - $signed({x0_ff[23], x0_ff});
   assign mul_p = dy * dxq;

   // restoring divide step
   logic [49:0] prod_neg;
   logic [24:0] trial, diff;
   logic        ge;
   assign prod_neg = -prod_ff;
   assign trial    = {rem_ff, num_ff[48]};
   assign ge       = (trial >= {1'b0, dx_ff});
   assign diff     = trial - {1'b0, dx_ff};

   // quotient sign and offset by y0, saturated
   logic [49:0]        q_mag, q_sgn;
   logic signed [50:0] div_sum;
   logic [23:0]        div_val;
   assign q_mag   = {1'b0, num_ff};
   assign q_sgn   = neg_ff ? -q_mag : q_mag;
   assign div_sum = $signed({{27{y0_ff[23]}}, y0_ff}) + $signed({q_sgn[49], q_sgn});
   always_comb begin
      if (div_sum < -51'sd8388608) div_val = LOG_MIN;
      else if (div_sum > 51'sd8388607) div_val = LOG_MAX;
      else div_val = div_sum[23:0];
   end

   // exp2 product step
   logic [61:0] r_prod;
   logic        f_bit;
   assign r_prod = r_ff * exp_c[cmd.cnt[3:0]];
   assign f_bit  = lq_ff[4'd15 - cmd.cnt[3:0]];

   // float packing of the exp2 result
   logic [31:0] exp_bits;
   always_comb begin
      if ($signed(e_ff) > 9'sd0) exp_bits = {1'b0, e_ff[7:0], r_ff[29:7]};
      else if (e_ff == 9'd0) exp_bits = {9'b0, r_ff[30:8]};
      else exp_bits = {10'b0, r_ff[30:9]};
   end

   // table read address
   always_comb begin
      case (cmd.op)
         OP_SHIFT_READ: rd_addr = AW'(sh_ff - CW'(1));
         OP_READ_A:     rd_addr = seg_a[AW-1:0];
         OP_READ_B:     rd_addr = seg_b[AW-1:0];
         default:       rd_addr = idx_ff[AW-1:0];
      endcase
   end

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_x    = lx_ff;
      wr_y    = ly_ff;
      case (cmd.op)
         OP_SHIFT_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = sh_ff[AW-1:0];
            wr_x    = rx_ff;
            wr_y    = ry_ff;
         end
         OP_INSERT: wr_en = 1'b1;
         default:   wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
      end
      rx_ff <= mem_x[rd_addr];
      ry_ff <= mem_y[rd_addr];
   end

   // command decode
   always_comb begin
      word_in     = word_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      sh_in       = sh_ff;
      sq_in       = sq_ff;
      frac_in     = frac_ff;
      ip_in       = ip_ff;
      spec_in     = spec_ff;
      spec_val_in = spec_val_ff;
      lx_in       = lx_ff;
      ly_in       = ly_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      x1_in       = x1_ff;
      y1_in       = y1_ff;
      prod_in     = prod_ff;
      dx_in       = dx_ff;
      neg_in      = neg_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      lq_in       = lq_ff;
      r_in        = r_ff;
      e_in        = e_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      case (cmd.op)
         OP_CAPTURE: word_in = req_word;
         OP_CLEAR:   count_in = '0;
         OP_EMIT_ERR: begin
            strobe_in           = 1'b1;
            rsp_in.result_value = '0;
            rsp_in.status       = 1'b1;
         end
         OP_LOG_SETUP_X, OP_LOG_SETUP_Y: begin
            frac_in     = '0;
            spec_in     = 1'b0;
            spec_val_in = LOG_MAX;
            ip_in       = {1'b0, src_ex} - 9'd127;
            sq_in       = {1'b1, src_man, 7'b0};
            if (src_ex == 8'hFF) begin
               spec_in = 1'b1;
            end else if (src_ex == 8'h00) begin
               if (src_man == '0) begin
                  spec_in     = 1'b1;
                  spec_val_in = LOG_ZERO;
               end else begin
                  ip_in = {4'b0, lead_p} - 9'd149;
                  sq_in = sub_sq;
               end
            end
         end
         OP_LOG_STEP: begin
            if (sq_t[31]) begin
               sq_in   = sq_t[31:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               sq_in   = sq_t[30:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
         end
         OP_LOG_FIN_X: begin
            lx_in  = log_val;
            idx_in = '0;
         end
         OP_LOG_FIN_Y: begin
            ly_in  = log_val;
            idx_in = '0;
         end
         OP_IDX_INC:     idx_in = idx_ff + CW'(1);
         OP_SH_INIT:     sh_in = count_ff;
         OP_SHIFT_WRITE: sh_in = sh_ff - CW'(1);
         OP_INSERT:      count_in = count_ff + CW'(1);
         OP_READ_B: begin
            x0_in = rx_ff;
            y0_in = ry_ff;
         end
         OP_LATCH_B: begin
            x1_in = rx_ff;
            y1_in = ry_ff;
         end
         OP_MULT: begin
            prod_in = mul_p;
            dx_in   = x1_ff - x0_ff;
         end
         OP_SET_LQ_RY:  lq_in = ry_ff;
         OP_SET_LQ_END: lq_in = (idx_ff == '0) ? y0_ff : y1_ff;
         OP_DIV_INIT: begin
            neg_in = prod_ff[49];
            num_in = prod_ff[49] ? prod_neg[48:0] : prod_ff[48:0];
            rem_in = '0;
         end
         OP_DIV_STEP: begin
            rem_in = ge ? diff[23:0] : trial[23:0];
            num_in = {num_ff[47:0], ge};
         end
         OP_DIV_FIN: lq_in = div_val;
         OP_EXP_INIT: begin
            r_in = 31'd1 << 30;
            e_in = $signed({lq_ff[23], lq_ff[23:16]}) + 9'sd127;
         end
         OP_EXP_STEP: begin
            if (f_bit) r_in = r_prod[60:30];
         end
         OP_EMIT: begin
            strobe_in           = 1'b1;
            rsp_in.result_value = exp_bits;
            rsp_in.status       = 1'b0;
         end
         default: strobe_in = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      idx_ff      <= idx_in;
      sh_ff       <= sh_in;
      sq_ff       <= sq_in;
      frac_ff     <= frac_in;
      ip_ff       <= ip_in;
      spec_ff     <= spec_in;
      spec_val_ff <= spec_val_in;
      lx_ff       <= lx_in;
      ly_ff       <= ly_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      prod_ff     <= prod_in;
      dx_ff       <= dx_in;
      neg_ff      <= neg_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      lq_ff       <= lq_in;
      r_ff        <= r_in;
      e_ff        <= e_in;
      rsp_ff      <= rsp_in;
   end

   // status to the controller
   always_comb begin
      stat.kind      = word_ff.kind;
      stat.full      = (count_ff == CW'(TABLE_DEPTH));
      stat.few       = (count_ff < CW'(2));
      stat.at_end    = (idx_ff == count_ff);
      stat.sh_at_pos = (sh_ff == idx_ff);
      stat.scan_go   = (word_ff.kind == KIND_LOAD) ?
                       ($signed(rx_ff) <= $signed(lx_ff)) :
                       ($signed(lx_ff) > $signed(rx_ff));
      stat.eq        = (rx_ff == lx_ff);
      stat.dx_zero   = (dx_ff == '0);
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ----- sv/log_log_table_interpolator_core.sv -----
// ============================================================================
// log_log_table_interpolator_core
// Log-log table interpolator: sorted point table with log2/exp2 conversion.
// ============================================================================
// Issue a word by raising start while busy is low; it is taken at that edge
// and busy stays high until the block can take the next word. A query gives
// exactly one result word, shown for a single cycle with rsp_strobe high;
// there is no hold-off, so the receiver must take it in that cycle. Load,
// clear and unused kinds give no result. A load runs two 16-step log2
// squaring passes, a scan of the table memory, then one read and one
// write per entry moved. A query runs the log2 pass and the scan, then
// segment fetch, multiply, the 49-step restoring divide and the 16-step
// exp2 product; an exact match goes straight to the exp2 product. The
// table memory read is registered and the divider gives one quotient bit
// per cycle.
module log_log_table_interpolator_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  llti_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output llti_pkg::rsp_word_type rsp_word
);
   import llti_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   llti_controller u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // tables and arithmetic
   llti_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_word   (req_word),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ----- bench/testbench.sv -----
// ============================================================================
// testbench
// Self-checking bench for the log-log table interpolator core: directed words,
// then loads, clears, queries and unused kinds in random bursts; a local model
// of the table in Q8.16 log2 predicts every query result, and a scoreboard compares them.
// ============================================================================
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import llti_pkg::*;

   localparam int DEPTH       = 64;
   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE      = 300;
   localparam int MIN_Q       = -8388608;
   localparam int MAX_Q       = 8388607;
   localparam int ZERO_Q      = -8272823;
   localparam longint FIX_ONE = 64'd1 << 30;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // ------------------------------------------------------------------
   // Interpolation predictor and expected-word store
   // ------------------------------------------------------------------
   class interp_scoreboard;
      int            lx_tab[DEPTH];
      int            ly_tab[DEPTH];
      int            npts;
      rsp_word_type  pending[$];
      int            errors;
      int            checked;
      int            loads, queries, clears, ignored;

      function int sat_q(longint v);
         if (v < MIN_Q) return MIN_Q;
         if (v > MAX_Q) return MAX_Q;
         return int'(v);
      endfunction

      // float bits -> Q8.16 log2 by repeated squaring
      function int float_to_log(logic [31:0] b);
         logic [7:0]  ex;
         logic [22:0] man;
         longint      ip;
         logic [63:0] y;
         logic [15:0] fr;
         int          p;
         ex = b[30:23];
         man = b[22:0];
         fr = '0;
         if (ex == 8'hFF) return MAX_Q;
         if (ex == 0) begin
            if (man == 0) return ZERO_Q;
            p = 22;
            while (man[p] == 1'b0) p--;
            ip = p - 149;
            y = 64'(man) << (30 - p);
         end else begin
            ip = longint'(ex) - 127;
            y = FIX_ONE | (64'(man) << 7);
         end
         for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            fr = fr << 1;
            if (y >= 2 * FIX_ONE) begin
               y = y >> 1;
               fr[0] = 1'b1;
            end
         end
         return sat_q(ip * 65536 + longint'(fr));
      endfunction

      function logic [63:0] isqrt(logic [63:0] v);
         logic [63:0] r, bt;
         r = 0;
         bt = 64'd1 << 62;
         while (bt > v) bt = bt >> 2;
         while (bt != 0) begin
            if (v >= r + bt) begin
               v = v - (r + bt);
               r = (r >> 1) + bt;
            end else begin
               r = r >> 1;
            end
            bt = bt >> 2;
         end
         return r;
      endfunction

      // Q8.16 log2 -> float bits via product of 2^(2^-k)
      function logic [31:0] log_to_float(int l);
         logic [15:0] f;
         longint      e;
         logic [63:0] r, c;
         f = l[15:0];
         e = ((longint'(l) - longint'(f)) / 65536) + 127;
         r = FIX_ONE;
         c = 2 * FIX_ONE;
         for (int k = 1; k <= 16; k++) begin
            c = isqrt(c << 30);
            if (f[16-k]) r = (r * c) >> 30;
         end
         if (e > 0) return (32'(e) << 23) | 32'((r - FIX_ONE) >> 7);
         return 32'(r >> (8 - e));
      endfunction

      function void reset_state();
         npts = 0;
      endfunction

      // note one accepted request word
      function void note_request(req_word_type w);
         int lx, ly, pos, idx, a, b;
         longint x0, x1, y0, y1, dx, ly64;
         rsp_word_type r;
         case (w.kind)
            KIND_CLEAR: begin
               npts = 0;
               clears++;
            end
            KIND_LOAD: begin
               loads++;
               lx = float_to_log(w.x_value);
               ly = float_to_log(w.y_value);
               if (npts < DEPTH) begin
                  pos = 0;
                  while (pos < npts && lx_tab[pos] <= lx) pos++;
                  for (int i = npts; i > pos; i--) begin
                     lx_tab[i] = lx_tab[i-1];
                     ly_tab[i] = ly_tab[i-1];
                  end
                  lx_tab[pos] = lx;
                  ly_tab[pos] = ly;
                  npts++;
               end
            end
            KIND_QUERY: begin
               queries++;
               r.result_value = '0;
               r.status = 1'b0;
               if (npts < 2) begin
                  r.status = 1'b1;
               end else begin
                  lx = float_to_log(w.x_value);
                  idx = 0;
                  while (idx < npts && lx > lx_tab[idx]) idx++;
                  if (idx < npts && lx == lx_tab[idx]) begin
                     r.result_value = log_to_float(ly_tab[idx]);
                  end else begin
                     if (idx == 0) begin
                        a = 0; b = 1;
                     end else if (idx >= npts) begin
                        a = npts - 2; b = npts - 1;
                     end else begin
                        a = idx - 1; b = idx;
                     end
                     x0 = lx_tab[a]; x1 = lx_tab[b];
                     y0 = ly_tab[a]; y1 = ly_tab[b];
                     dx = x1 - x0;
                     if (dx == 0) ly64 = (idx == 0) ? y0 : y1;
                     else ly64 = y0 + ((y1 - y0) * (longint'(lx) - x0)) / dx;
                     r.result_value = log_to_float(sat_q(ly64));
                  end
               end
               pending.push_back(r);
            end
            default: ignored++;
         endcase
      endfunction

      // compare one result word against the oldest expectation
      function void check_result(rsp_word_type got);
         rsp_word_type exp_w;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected result word value=%h status=%b",
                        got.result_value, got.status);
            return;
         end
         exp_w = pending.pop_front();
         if (got.result_value !== exp_w.result_value || got.status !== exp_w.status) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: result word %0d: exp value=%h status=%b, got value=%h status=%b",
                        checked, exp_w.result_value, exp_w.status,
                        got.result_value, got.status);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   interp_scoreboard sb = new();
   int idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   log_log_table_interpolator_core #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   // accept monitor: note requests and check results at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_word);
         if (rsp_strobe) sb.check_result(rsp_word);
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on cycles with no accepted word and no result word
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   int gap_left = 0;
   int burst_left = 0;

   // issue one word, honoring burst/gap pacing; start stays high between
   // back-to-back words and drops only for a gap
   task automatic send_word(logic [1:0] k, logic [31:0] xv, logic [31:0] yv);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end
      if (gap_left > 0) start <= 1'b0;
      while (gap_left > 0) begin
         @(posedge clock);
         gap_left--;
      end
      start <= 1'b1;
      req_word <= '{kind: k, x_value: xv, y_value: yv};
      do @(posedge clock); while (busy);
      burst_left--;
   endtask

   // mostly positive float with random exponent spread, sometimes special or random bits
   function automatic logic [31:0] rand_float();
      int s;
      s = $urandom_range(0, 19);
      if (s == 0) return 32'h0000_0000;
      if (s == 1) return {1'b0, 8'h00, 23'($urandom)};
      if (s == 2) return {1'b0, 8'hFF, 23'($urandom_range(0, 1) ? $urandom : 0)};
      if (s == 3) return $urandom;
      return {1'b0, 8'($urandom_range(100, 160)), 23'($urandom)};
   endfunction

   task automatic fill_table(int n);
      for (int i = 0; i < n; i++) send_word(KIND_LOAD, rand_float(), rand_float());
   endtask

   int sent;

   initial begin
      sb.reset_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty and one-point tables, specials, exact hits, ends
      send_word(KIND_QUERY, 32'h3F80_0000, 32'hFFFF_FFFF);
      send_word(KIND_LOAD, 32'h3F80_0000, 32'h4000_0000);
      send_word(KIND_QUERY, 32'h3F80_0000, 0);
      send_word(KIND_LOAD, 32'h4120_0000, 32'h0000_0000);
      send_word(KIND_QUERY, 32'h3F80_0000, 0);
      send_word(KIND_QUERY, 32'h40A0_0000, 0);
      send_word(KIND_QUERY, 32'h0000_0000, 0);
      send_word(KIND_QUERY, 32'h0000_0001, 0);
      send_word(KIND_QUERY, 32'h7F80_0000, 0);
      send_word(KIND_QUERY, 32'hFFFF_FFFF, 0);
      send_word(KIND_QUERY, 32'h7F7F_FFFF, 0);
      send_word(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(KIND_LOAD, 32'h4120_0000, 32'h7F80_0000);
      send_word(KIND_LOAD, 32'h3F80_0000, 32'h0000_0001);
      send_word(KIND_QUERY, 32'h4220_0000, 0);
      send_word(KIND_QUERY, 32'h3DCC_CCCD, 0);
      send_word(KIND_QUERY, 32'h4120_0000, 0);
      send_word(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(KIND_QUERY, 32'h3F80_0000, 0);
      fill_table(DEPTH + 2);           // overfill: extra loads dropped
      send_word(KIND_QUERY, 32'h4000_0000, 0);
      send_word(KIND_CLEAR, 0, 0);

      // random: well-formed fill-then-query phases plus noise
      sent = 0;
      while (sent < 610) begin
         int n;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
         for (int i = 0; i < n; i++) send_word(KIND_LOAD, rand_float(), rand_float());
         sent += n;
         repeat ($urandom_range(3, 20)) begin
            int r;
            r = $urandom_range(0, 19);
            if (r == 0) send_word(KIND_UNUSED, $urandom, $urandom);
            else if (r == 1) send_word(KIND_LOAD, rand_float(), $urandom);
            else send_word(KIND_QUERY, rand_float(), $urandom);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            send_word(KIND_CLEAR, $urandom, $urandom);
            sent++;
         end
      end
      start <= 1'b0;

      // drain
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d loads, %0d queries, %0d clears, %0d unused kinds",
               sb.loads, sb.queries, sb.clears, sb.ignored);
      $display("%0d result words checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/llti_pkg.sv
sv/llti_controller.sv
sv/llti_datapath.sv
sv/log_log_table_interpolator_core.sv
bench/testbench.sv
